@@ design/mono_framebuffer_draw_top_defines.svh @@
// Assertion macros used by the framebuffer draw engine checker.
`ifndef MONO_FRAMEBUFFER_DRAW_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MFD_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("mfd check failed");

// Check that cons holds in the cycle after ante.
`define MFD_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("mfd check failed");

`endif

@@ design/mfd_pkg.sv @@
// Shared constants, types and command/status structs of the framebuffer draw engine.
`default_nettype none
package mfd_pkg;

  localparam int PANEL_WIDTH  = 200;
  localparam int PANEL_HEIGHT = 200;
  localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;

  localparam int XW = ($clog2(PANEL_WIDTH) > 3) ? $clog2(PANEL_WIDTH) : 3;
  localparam int YW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int BW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_PIXEL   = 3'd1;
  localparam logic [2:0] OP_OUTLINE = 3'd2;
  localparam logic [2:0] OP_FILL    = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [7:0] PIX_ALL  = 8'hFF;
  localparam logic [7:0] PIX_NONE = 8'h00;

  typedef logic signed [10:0] coord_t;
  typedef logic signed [11:0] wcoord_t;

  typedef struct packed {
    logic [12:0] byte_address;
    logic        paint_black;
    coord_t      y_end;
    coord_t      x_end;
    coord_t      y_start;
    coord_t      x_start;
  } item_t;

  // Which box the walker loads from the captured corners.
  typedef enum logic [2:0] {
    RECT_BOX,
    RECT_DOT,
    RECT_TOP,
    RECT_BOT,
    RECT_LEFT,
    RECT_RIGHT
  } rect_t;

  typedef struct packed {
    logic  capture;
    logic  load_rect;
    rect_t rect_sel;
    logic  rmw_rd;
    logic  rmw_wr;
    logic  byte_rd;
    logic  clr_wr;
  } mfd_cmd_t;

  typedef struct packed {
    logic rect_empty;
    logic walk_last;
    logic clr_last;
  } mfd_sts_t;

endpackage
`default_nettype wire

@@ design/mfd_datapath.sv @@
// Datapath: captured request, clipped box walker, byte masks and the frame memory.
`default_nettype none
module mfd_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mfd_pkg::item_t   item,
  input  wire mfd_pkg::mfd_cmd_t cmd,
  output mfd_pkg::mfd_sts_t     sts,
  output logic [7:0]            rd_byte
);
  import mfd_pkg::*;

  localparam wcoord_t XMAX = wcoord_t'(PANEL_WIDTH - 1);
  localparam wcoord_t YMAX = wcoord_t'(PANEL_HEIGHT - 1);

  logic [7:0] mem [STORE_BYTES];

  coord_t      xs_r, ys_r, xe_r, ye_r;
  logic        paint_black_r;
  logic [12:0] byte_address_r;
  logic        addr_ok_r;

  logic [XW-1:0] x_lo_r, x_hi_r;
  logic [YW-1:0] y_r, y_hi_r;
  logic [BW-1:0] byte_r, byte_hi_r;
  logic [AW-1:0] row_base_r;
  logic [AW-1:0] sweep_r;
  logic [7:0]    rd_data_r;

  coord_t  rx0, ry0, rx1, ry1;
  wcoord_t xa, xb, ya, yb;
  logic [BW-1:0] byte_lo;
  logic [AW-1:0] walk_addr, mem_raddr, mem_waddr;
  logic [7:0]    lmask, rmask, mask, mem_wdata;
  logic          mem_we, mem_re;

  always_comb begin
    case (cmd.rect_sel)
      RECT_BOX:   begin rx0 = xs_r; ry0 = ys_r; rx1 = xe_r; ry1 = ye_r; end
      RECT_DOT:   begin rx0 = xs_r; ry0 = ys_r; rx1 = xs_r; ry1 = ys_r; end
      RECT_TOP:   begin rx0 = xs_r; ry0 = ys_r; rx1 = xe_r; ry1 = ys_r; end
      RECT_BOT:   begin rx0 = xs_r; ry0 = ye_r; rx1 = xe_r; ry1 = ye_r; end
      RECT_LEFT:  begin rx0 = xs_r; ry0 = ys_r; rx1 = xs_r; ry1 = ye_r; end
      RECT_RIGHT: begin rx0 = xe_r; ry0 = ys_r; rx1 = xe_r; ry1 = ye_r; end
      default:    begin rx0 = xs_r; ry0 = ys_r; rx1 = xe_r; ry1 = ye_r; end
    endcase
  end

  // Clip to the panel; a clipped box that ends up inverted is empty.
  always_comb begin
    xa = (rx0 < 0) ? wcoord_t'(0) : wcoord_t'(rx0);
    ya = (ry0 < 0) ? wcoord_t'(0) : wcoord_t'(ry0);
    xb = (wcoord_t'(rx1) > XMAX) ? XMAX : wcoord_t'(rx1);
    yb = (wcoord_t'(ry1) > YMAX) ? YMAX : wcoord_t'(ry1);
  end

  assign sts.rect_empty = (xa > xb) || (ya > yb);
  assign sts.walk_last  = (byte_r == byte_hi_r) && (y_r == y_hi_r);
  assign sts.clr_last   = (sweep_r == AW'(STORE_BYTES - 1));

  assign byte_lo   = BW'(x_lo_r >> 3);
  assign walk_addr = row_base_r + AW'(byte_r);

  always_comb begin
    lmask = (byte_r == byte_lo)   ? (PIX_ALL >> x_lo_r[2:0]) : PIX_ALL;
    rmask = (byte_r == byte_hi_r) ? (PIX_ALL << (3'd7 - x_hi_r[2:0])) : PIX_ALL;
    mask  = lmask & rmask;
  end

  always_comb begin
    mem_we    = cmd.clr_wr | cmd.rmw_wr;
    mem_re    = cmd.rmw_rd | cmd.byte_rd;
    mem_waddr = cmd.clr_wr ? sweep_r : walk_addr;
    mem_raddr = cmd.byte_rd ? AW'(byte_address_r) : walk_addr;
    if (cmd.clr_wr) begin
      mem_wdata = paint_black_r ? PIX_NONE : PIX_ALL;
    end else if (paint_black_r) begin
      mem_wdata = rd_data_r & ~mask;
    end else begin
      mem_wdata = rd_data_r | mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // The power-up sweep paints black, so the paint flag and sweep pointer reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paint_black_r <= 1'b1;
      sweep_r       <= '0;
    end else begin
      if (cmd.capture) begin
        paint_black_r <= item.paint_black;
      end
      if (cmd.clr_wr) begin
        sweep_r <= sts.clr_last ? '0 : sweep_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xs_r           <= item.x_start;
      ys_r           <= item.y_start;
      xe_r           <= item.x_end;
      ye_r           <= item.y_end;
      byte_address_r <= item.byte_address;
      addr_ok_r      <= (32'(item.byte_address) < STORE_BYTES);
    end
    if (cmd.load_rect) begin
      x_lo_r     <= xa[XW-1:0];
      x_hi_r     <= xb[XW-1:0];
      y_r        <= ya[YW-1:0];
      y_hi_r     <= yb[YW-1:0];
      byte_r     <= BW'(xa[XW-1:0] >> 3);
      byte_hi_r  <= BW'(xb[XW-1:0] >> 3);
      row_base_r <= AW'(32'(ya[YW-1:0]) * ROW_BYTES);
    end else if (cmd.rmw_wr) begin
      // Advance across the row, then wrap to the next row.
      if (byte_r == byte_hi_r) begin
        byte_r     <= byte_lo;
        y_r        <= y_r + YW'(1);
        row_base_r <= row_base_r + AW'(ROW_BYTES);
      end else begin
        byte_r <= byte_r + BW'(1);
      end
    end
  end

  assign rd_byte = addr_ok_r ? rd_data_r : PIX_NONE;

endmodule
`default_nettype wire

@@ design/mfd_ctrl.sv @@
// Controller: sequences clears, box walks, outline segments and byte reads.
`default_nettype none
module mfd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [2:0]        in_op,
  output logic                   in_ready,
  input  wire logic              out_free,
  output logic                   out_load,
  output logic                   res_read,
  output mfd_pkg::mfd_cmd_t      cmd,
  input  wire mfd_pkg::mfd_sts_t sts
);
  import mfd_pkg::*;

  typedef enum logic [2:0] {
    S_BOOT,
    S_IDLE,
    S_CLEAR,
    S_LOAD,
    S_RD,
    S_WR,
    S_RDB,
    S_DONE
  } state_t;

  localparam logic [1:0] LAST_SEG = 2'd3;

  state_t     state_r;
  logic [2:0] op_r;
  logic [1:0] seg_r;
  logic       more_seg;
  rect_t      rect_sel;

  assign more_seg = (op_r == OP_OUTLINE) && (seg_r != LAST_SEG);

  always_comb begin
    unique case (op_r)
      OP_PIXEL:   rect_sel = RECT_DOT;
      OP_OUTLINE: begin
        unique case (seg_r)
          2'd0:    rect_sel = RECT_TOP;
          2'd1:    rect_sel = RECT_BOT;
          2'd2:    rect_sel = RECT_LEFT;
          default: rect_sel = RECT_RIGHT;
        endcase
      end
      default:    rect_sel = RECT_BOX;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.rect_sel  = rect_sel;
    cmd.capture   = (state_r == S_IDLE) && in_valid;
    cmd.load_rect = (state_r == S_LOAD);
    cmd.rmw_rd    = (state_r == S_RD);
    cmd.rmw_wr    = (state_r == S_WR);
    cmd.byte_rd   = (state_r == S_RDB);
    cmd.clr_wr    = (state_r == S_BOOT) || (state_r == S_CLEAR);
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && out_free;
  assign res_read = (op_r == OP_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
      op_r    <= OP_CLEAR;
      seg_r   <= '0;
    end else begin
      unique case (state_r)
        S_BOOT: begin
          if (sts.clr_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= in_op;
            seg_r <= '0;
            unique case (in_op) inside
              OP_CLEAR:                     state_r <= S_CLEAR;
              OP_PIXEL, OP_OUTLINE, OP_FILL: state_r <= S_LOAD;
              OP_READ:                      state_r <= S_RDB;
              default:                      state_r <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          if (sts.clr_last) state_r <= S_DONE;
        end
        S_LOAD: begin
          if (!sts.rect_empty) begin
            state_r <= S_RD;
          end else if (more_seg) begin
            seg_r <= seg_r + 2'd1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_RD: begin
          state_r <= S_WR;
        end
        S_WR: begin
          if (!sts.walk_last) begin
            state_r <= S_RD;
          end else if (more_seg) begin
            seg_r   <= seg_r + 2'd1;
            state_r <= S_LOAD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_RDB: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/mono_framebuffer_draw_top.sv @@
// Top level of the one-bit-per-pixel framebuffer draw engine with its result register.
// One request at a time; the result sits in an output register, a new request may enter meanwhile.
// Read byte: read the byte, then load the result; set pixel: load the box, read and write its byte.
// Fill/outline: per box a load step plus a read and a write per touched byte, outline 4 boxes.
// Clear all: writes all 5000 bytes, one byte per write-port cycle, then loads the result.
// Reset: synchronous active low; afterwards a sweep blacks all 5000 bytes of the store, in_tready low.
`default_nettype none
module mono_framebuffer_draw_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [10:0] x_start, [21:11] y_start, [32:22] x_end, [43:33] y_end,
  // [44] paint_black, [57:45] byte_address, [63:58] zero
  input  wire logic [63:0] in_tdata,
  // [2:0] operation
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] read_data
  output logic [7:0]       out_tdata,
  // [0] was_read
  output logic [0:0]       out_tuser
);
  import mfd_pkg::*;

  item_t      item;
  mfd_cmd_t   cmd;
  mfd_sts_t   sts;
  logic [7:0] rd_byte;
  logic       out_free, out_load, res_read;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_read_r;

  always_comb begin
    item.x_start      = coord_t'(in_tdata[10:0]);
    item.y_start      = coord_t'(in_tdata[21:11]);
    item.x_end        = coord_t'(in_tdata[32:22]);
    item.y_end        = coord_t'(in_tdata[43:33]);
    item.paint_black  = in_tdata[44];
    item.byte_address = in_tdata[57:45];
  end

  assign out_free = !out_valid_r || out_tready;

  mfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .out_free (out_free),
    .out_load (out_load),
    .res_read (res_read),
    .cmd      (cmd),
    .sts      (sts)
  );

  mfd_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .cmd     (cmd),
    .sts     (sts),
    .rd_byte (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Only reads carry data; everything else reports zero.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_read ? rd_byte : PIX_NONE;
      out_read_r <= res_read;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_read_r;

endmodule
`default_nettype wire

@@ design/mfd_checker.sv @@
// Port-level checker for the framebuffer draw engine, bound to the top level.
`default_nettype none
`include "mono_framebuffer_draw_top_defines.svh"
module mfd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [0:0] out_tuser
);

  // Hold a stalled result.
  `MFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // Non-read results carry zero data.
  `MFD_ASSERT_NOW(a_zero_data, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == 8'h00)
  // One request at a time: busy right after an accept.
  `MFD_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // The power-up sweep holds off requests.
  `MFD_ASSERT_NOW(a_boot, clk, rst_n, !$past(rst_n), !in_tready)

endmodule

bind mono_framebuffer_draw_top mfd_checker u_mfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ test/mono_framebuffer_draw_top_test.sv @@
// Self-checking testbench for the one-bit-per-pixel framebuffer draw engine.
`timescale 1ns / 1ps
module mono_framebuffer_draw_top_test;
  import mfd_pkg::*;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [7:0] read_data;
    logic       was_read;
  } draw_result_t;

  class frame_scoreboard;
    logic [7:0]   shadow_store [STORE_BYTES];
    draw_result_t awaited_results [$];
    int           mismatches;
    int           results_checked;
    int           op_seen [8];

    function new();
      foreach (shadow_store[i]) shadow_store[i] = PIX_NONE;
      mismatches = 0;
      results_checked = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void plot_pixel(int x, int y, bit black);
      int idx;
      logic [7:0] mask;
      if (x < 0 || x >= PANEL_WIDTH || y < 0 || y >= PANEL_HEIGHT) return;
      idx = y * ROW_BYTES + x / 8;
      mask = 8'h80 >> (x % 8);
      if (black) shadow_store[idx] = shadow_store[idx] & ~mask;
      else shadow_store[idx] = shadow_store[idx] | mask;
    endfunction

    function void fill_box(int x0, int y0, int x1, int y1, bit black);
      int xa, xb, ya, yb;
      xa = (x0 < 0) ? 0 : x0;
      xb = (x1 > PANEL_WIDTH - 1) ? PANEL_WIDTH - 1 : x1;
      ya = (y0 < 0) ? 0 : y0;
      yb = (y1 > PANEL_HEIGHT - 1) ? PANEL_HEIGHT - 1 : y1;
      for (int y = ya; y <= yb; y++)
        for (int x = xa; x <= xb; x++) plot_pixel(x, y, black);
    endfunction

    // Edges use the raw corners; each pixel is clipped on its own.
    function void outline_box(int x0, int y0, int x1, int y1, bit black);
      int xa, xb, ya, yb;
      xa = (x0 < 0) ? 0 : x0;
      xb = (x1 > PANEL_WIDTH - 1) ? PANEL_WIDTH - 1 : x1;
      ya = (y0 < 0) ? 0 : y0;
      yb = (y1 > PANEL_HEIGHT - 1) ? PANEL_HEIGHT - 1 : y1;
      for (int x = xa; x <= xb; x++) begin
        plot_pixel(x, y0, black);
        plot_pixel(x, y1, black);
      end
      for (int y = ya; y <= yb; y++) begin
        plot_pixel(x0, y, black);
        plot_pixel(x1, y, black);
      end
    endfunction

    function void note_request(logic [2:0] op, item_t req);
      draw_result_t res;
      int xs, ys, xe, ye;
      xs = int'($signed(req.x_start));
      ys = int'($signed(req.y_start));
      xe = int'($signed(req.x_end));
      ye = int'($signed(req.y_end));
      res.read_data = PIX_NONE;
      res.was_read = 1'b0;
      op_seen[op]++;
      case (op)
        OP_CLEAR: begin
          foreach (shadow_store[i]) shadow_store[i] = req.paint_black ? PIX_NONE : PIX_ALL;
        end
        OP_PIXEL: plot_pixel(xs, ys, req.paint_black);
        OP_OUTLINE: outline_box(xs, ys, xe, ye, req.paint_black);
        OP_FILL: fill_box(xs, ys, xe, ye, req.paint_black);
        OP_READ: begin
          res.was_read = 1'b1;
          if (req.byte_address < STORE_BYTES) res.read_data = shadow_store[req.byte_address];
        end
        default: ;
      endcase
      awaited_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [7:0] read_data, logic was_read);
      draw_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h was_read=%b", read_data, was_read));
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      if (read_data !== want.read_data)
        report_mismatch($sformatf("read_data %h, want %h", read_data, want.read_data));
      if (was_read !== want.was_read)
        report_mismatch($sformatf("was_read %b, want %b", was_read, want.was_read));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = OP_CLEAR;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;

  frame_scoreboard board = new();
  bit steady = 1'b0;

  mono_framebuffer_draw_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 23);
  end

  // Check the outgoing result before noting a new request in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser[0]);
      if (in_tvalid && in_tready) board.note_request(in_tuser, item_t'(in_tdata[57:0]));
    end
  end

  // Call right after a rising edge; returns at the edge that accepts the request.
  task automatic send_request(logic [2:0] op, int xs, int ys, int xe, int ye,
                              bit black, int addr);
    item_t req;
    req.x_start = coord_t'(xs);
    req.y_start = coord_t'(ys);
    req.x_end = coord_t'(xe);
    req.y_end = coord_t'(ye);
    req.paint_black = black;
    req.byte_address = 13'(addr);
    while (!steady && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, req};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int sel, xs, ys, xe, ye, addr, last_x, last_y, unused_sent;
    bit black;
    logic [2:0] op;
    last_x = 0;
    last_y = 0;
    unused_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_READ, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1);
    send_request(OP_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES);
    send_request(OP_READ, 0, 0, 0, 0, 1'b1, 8191);
    send_request(OP_PIXEL, 0, 0, 0, 0, 1'b1, 0);
    send_request(OP_PIXEL, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 1'b1, 0);
    send_request(OP_PIXEL, -1, 5, 0, 0, 1'b1, 0);
    send_request(OP_PIXEL, PANEL_WIDTH, 0, 0, 0, 1'b1, 0);
    send_request(OP_PIXEL, 1023, -1024, -1024, 1023, 1'b1, 8191);
    send_request(OP_READ, 0, 0, 0, 0, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1);
    send_request(OP_CLEAR, 0, 0, 0, 0, 1'b1, 0);
    send_request(OP_FILL, -1024, -1024, 1023, 1023, 1'b0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 1'b1, 0);
    send_request(OP_FILL, 3, 7, 12, 9, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 1'b0, 7 * ROW_BYTES);
    send_request(OP_FILL, 30, 30, 20, 40, 1'b0, 0);
    send_request(OP_OUTLINE, -5, 3, 30, 250, 1'b0, 0);
    // Columns are still drawn when the left edge lies right of the right edge.
    send_request(OP_OUTLINE, 60, 50, 40, 70, 1'b0, 0);
    send_request(OP_OUTLINE, 100, 100, 100, 100, 1'b0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 1'b0, 3 * ROW_BYTES);
    send_request(OP_READ, 0, 0, 0, 0, 1'b0, 100 * ROW_BYTES + 12);
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
      send_request(3'(c), 0, 0, 0, 0, 1'b0, 0);

    for (int n = 0; n < 96; n++) begin
      steady = (n >= 40 && n < 70);
      sel = $urandom_range(99);
      black = $urandom_range(1);
      addr = $urandom_range(8191);
      if ($urandom_range(99) < 15) begin
        xs = int'($urandom_range(2047)) - 1024;
        ys = int'($urandom_range(2047)) - 1024;
        xe = int'($urandom_range(2047)) - 1024;
        ye = int'($urandom_range(2047)) - 1024;
      end else begin
        xs = int'($urandom_range(PANEL_WIDTH + 30)) - 15;
        ys = int'($urandom_range(PANEL_HEIGHT + 30)) - 15;
        xe = xs + int'($urandom_range(30)) - 3;
        ye = ys + int'($urandom_range(20)) - 3;
      end
      if (sel < 4) op = OP_CLEAR;
      else if (sel < 24) op = OP_PIXEL;
      else if (sel < 44) op = OP_OUTLINE;
      else if (sel < 64) op = OP_FILL;
      else if (sel < 94) op = OP_READ;
      else op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      if (op == OP_READ) begin
        sel = $urandom_range(99);
        // Aim most reads at the area drawn last so they see painted bytes.
        if (sel < 60) addr = last_y * ROW_BYTES + last_x / 8;
        else if (sel < 70) addr = $urandom_range(8191, STORE_BYTES);
        else addr = $urandom_range(STORE_BYTES - 1);
      end else if (xs >= 0 && xs < PANEL_WIDTH && ys >= 0 && ys < PANEL_HEIGHT) begin
        last_x = xs;
        last_y = ys;
      end
      send_request(op, xs, ys, xe, ye, black, addr);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
      unused_sent += board.op_seen[c];
    $display("Sent %0d clears, %0d pixels, %0d outlines, %0d fills, %0d reads, %0d unused codes;",
             board.op_seen[OP_CLEAR], board.op_seen[OP_PIXEL], board.op_seen[OP_OUTLINE],
             board.op_seen[OP_FILL], board.op_seen[OP_READ], unused_sent);
    $display("checked %0d results, %0d mismatches.", board.results_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("mono_framebuffer_draw_top_test OK");
    end else begin
      $display("mono_framebuffer_draw_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #64_000_000;
    $display("timeout with %0d results outstanding", board.awaited_results.size());
    $display("mono_framebuffer_draw_top_test NOT OK");
    $finish;
  end
endmodule

@@ mono_framebuffer_draw_top.f @@
+incdir+design
design/mfd_pkg.sv
design/mfd_datapath.sv
design/mfd_ctrl.sv
design/mono_framebuffer_draw_top.sv
design/mfd_checker.sv
test/mono_framebuffer_draw_top_test.sv
